@@ src/atrse_pkg.sv @@
// Shared types, constants and helpers for the ANSI text to RTF stream encoder.
// No dependencies; every other file imports this package.
package atrse_pkg;

    localparam int CU_W            = 16;
    localparam int CMDQ_DEPTH_DEF  = 4;

    localparam logic [7:0] DEF_ATTR = 8'h07;

    // Characters the text path looks for or produces
    localparam logic [15:0] CH_LF    = 16'h000a;
    localparam logic [15:0] CH_CR    = 16'h000d;
    localparam logic [15:0] CH_SP    = 16'h0020;
    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_1     = 16'h0031;
    localparam logic [15:0] CH_9     = 16'h0039;
    localparam logic [15:0] CH_SEMI  = 16'h003b;
    localparam logic [15:0] CH_BSL   = 16'h005c;
    localparam logic [15:0] CH_M     = 16'h006d;
    localparam logic [15:0] CH_LBR   = 16'h007b;
    localparam logic [15:0] CH_RBR   = 16'h007d;
    localparam logic [15:0] CH_TILDE = 16'h007e;
    localparam logic [15:0] CH_HIGH  = 16'h0080;

    // SGR codes
    localparam logic [7:0] SGR_RESET   = 8'd0;
    localparam logic [7:0] SGR_BOLD    = 8'd1;
    localparam logic [7:0] SGR_UNDER   = 8'd4;
    localparam logic [7:0] SGR_INVERSE = 8'd7;
    localparam logic [7:0] SGR_FG_BASE = 8'd30;
    localparam logic [7:0] SGR_FG_DEF  = 8'd39;
    localparam logic [7:0] SGR_BG_BASE = 8'd40;
    localparam logic [7:0] SGR_BG_DEF  = 8'd49;
    localparam logic [7:0] SGR_FG_HI   = 8'd90;
    localparam logic [7:0] SGR_BG_HI   = 8'd100;

    typedef enum logic [2:0] {
        K_CHAR,   // copy code unit
        K_PAIR,   // backslash then one char
        K_LF,     // LF \par
        K_UNI,    // \u decimal \'3f
        K_ESC     // \cf \highlight [\ul|\ul0] space
    } t_kind;

    typedef enum logic [1:0] {
        UL_NONE,
        UL_ON,
        UL_OFF
    } t_ulchg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;   // char to copy, escaped char, or unicode value
        logic [2:0]  upow;    // index of leading decimal power for K_UNI
        logic [4:0]  fg;      // console color + 1
        logic [4:0]  bg;
        t_ulchg      ul;
    } t_cmd;

    typedef struct packed {
        logic [7:0] attr;
        logic       ul;
    } t_attr;

    // k * 10^p, indexed [p][k]
    localparam logic [16:0] DEC_MULT [5][10] = '{
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
          17'd90},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
          17'd800, 17'd900},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
          17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
          17'd60000, 17'd70000, 17'd80000, 17'd90000}
    };

    function automatic t_attr apply_code(input logic [7:0] a, input logic ul,
                                         input logic [7:0] c);
        t_attr      r;
        logic [7:0] off;
        r.attr = a;
        r.ul   = ul;
        off    = '0;
        if (c == SGR_RESET) begin
            r.attr = DEF_ATTR;
            r.ul   = 1'b0;
        end else if (c == SGR_BOLD) begin
            r.attr = a | 8'h08;
        end else if (c == SGR_UNDER) begin
            r.ul = 1'b1;
        end else if (c == SGR_INVERSE) begin
            r.attr = {a[3:0], a[7:4]};
        end else if (c == SGR_FG_DEF) begin
            r.attr = {a[7:4], DEF_ATTR[3:0]};
        end else if (c == SGR_BG_DEF) begin
            r.attr = {DEF_ATTR[7:4], a[3:0]};
        end else if (c >= SGR_FG_BASE && c <= SGR_FG_BASE + 8'd7) begin
            off    = c - SGR_FG_BASE;
            r.attr = {a[7:4], off[3:0]};
        end else if (c >= SGR_BG_BASE && c <= SGR_BG_BASE + 8'd7) begin
            off    = c - SGR_BG_BASE;
            r.attr = {off[3:0], a[3:0]};
        end else if (c >= SGR_FG_HI && c <= SGR_FG_HI + 8'd7) begin
            off    = c - SGR_FG_HI;
            r.attr = {a[7:4], 1'b1, off[2:0]};
        end else if (c >= SGR_BG_HI && c <= SGR_BG_HI + 8'd7) begin
            off    = c - SGR_BG_HI;
            r.attr = {1'b1, off[2:0], a[3:0]};
        end
        return r;
    endfunction

    // ANSI nibble to console nibble (swap bits 0 and 2), plus one
    function automatic logic [4:0] console_plus1(input logic [3:0] v);
        return {1'b0, v[3], v[0], v[1], v[2]} + 5'd1;
    endfunction

endpackage

@@ src/atrse_if.sv @@
// Stream interfaces for the encoder's input and output channels.
// Depends on atrse_pkg for the code unit width.
interface atrse_in_if import atrse_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            mode;
    logic [CU_W-1:0] code_unit;
    logic            seq_end;

    modport source (output valid, mode, code_unit, seq_end, input ready);
    modport sink   (input valid, mode, code_unit, seq_end, output ready);
endinterface

interface atrse_out_if import atrse_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CU_W-1:0] out_char;
    logic            out_last;

    modport source (output valid, out_char, out_last, input ready);
    modport sink   (input valid, out_char, out_last, output ready);
endinterface

@@ src/atrse_front.sv @@
// Front end: accepts input beats, tracks SGR parse state, classifies each
// beat into one expansion command. Depends on atrse_pkg and atrse_in_if.
module atrse_front import atrse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atrse_in_if.sink    i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       r_ul_on;
    logic [7:0] r_attr;
    logic       r_wul;
    logic [7:0] r_acc;
    logic [1:0] r_sp;
    logic       r_pa;

    logic        n_ul_on;
    logic [7:0]  n_attr;
    logic        n_wul;
    logic [7:0]  n_acc;
    logic [1:0]  n_sp;
    logic        n_pa;

    logic        fire;
    logic [15:0] c;
    logic        is_digit;
    logic        sp0;
    logic        sp_ge2;
    logic [7:0]  attr_b;
    logic [7:0]  acc_b;
    logic        wul_b;
    logic        pa_b;
    logic [11:0] acc_x10;
    t_attr       app;
    logic        emit;

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && i_in.ready;
    assign c          = i_in.code_unit;

    always_comb begin
        is_digit = (c >= CH_0) && (c <= CH_9);
        sp0      = (r_sp == 2'd0);
        sp_ge2   = r_sp[1];
        // a new sequence starts from defaults
        attr_b   = sp0 ? DEF_ATTR : r_attr;
        wul_b    = sp0 ? 1'b0 : r_wul;
        acc_b    = sp0 ? 8'd0 : r_acc;
        pa_b     = sp0 ? 1'b1 : r_pa;
        acc_x10  = {1'b0, acc_b, 3'b000} + {3'b000, acc_b, 1'b0} + {8'h00, c[3:0]};
        app      = apply_code(attr_b, wul_b, acc_b);

        n_attr = attr_b;
        n_wul  = wul_b;
        n_acc  = acc_b;
        n_pa   = pa_b;
        if (sp_ge2 && pa_b) begin
            if (is_digit) begin
                n_acc = (acc_x10 > 12'd255) ? 8'hff : acc_x10[7:0];
            end else begin
                n_attr = app.attr;
                n_wul  = app.ul;
                n_acc  = 8'd0;
                if (c != CH_SEMI) begin
                    n_pa = 1'b0;
                end
            end
        end

        emit    = i_in.seq_end && sp_ge2 && (c == CH_M);
        n_ul_on = emit ? n_wul : r_ul_on;

        if (i_in.seq_end) begin
            n_sp  = 2'd0;
            n_acc = 8'd0;
            n_pa  = 1'b1;
        end else begin
            n_sp = (r_sp == 2'd3) ? 2'd3 : r_sp + 2'd1;
        end
    end

    // command build
    always_comb begin
        o_cmd.kind  = K_CHAR;
        o_cmd.value = c;
        if (c >= 16'd10000) begin
            o_cmd.upow = 3'd4;
        end else if (c >= 16'd1000) begin
            o_cmd.upow = 3'd3;
        end else begin
            o_cmd.upow = 3'd2;
        end
        o_cmd.fg = console_plus1(n_attr[3:0]);
        o_cmd.bg = console_plus1(n_attr[7:4]);
        if (n_wul && !r_ul_on) begin
            o_cmd.ul = UL_ON;
        end else if (!n_wul && r_ul_on) begin
            o_cmd.ul = UL_OFF;
        end else begin
            o_cmd.ul = UL_NONE;
        end

        if (i_in.mode) begin
            o_cmd.kind = K_ESC;
        end else if (c == CH_BSL || c == CH_LBR || c == CH_RBR) begin
            o_cmd.kind = K_PAIR;
        end else if (c == CH_SP) begin
            o_cmd.kind  = K_PAIR;
            o_cmd.value = CH_TILDE;
        end else if (c == CH_LF) begin
            o_cmd.kind = K_LF;
        end else if (c >= CH_HIGH) begin
            o_cmd.kind = K_UNI;
        end

        o_push = fire && (i_in.mode ? emit : (c != CH_CR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul_on <= 1'b0;
            r_attr  <= DEF_ATTR;
            r_wul   <= 1'b0;
            r_acc   <= 8'd0;
            r_sp    <= 2'd0;
            r_pa    <= 1'b1;
        end else if (fire && i_in.mode) begin
            r_ul_on <= n_ul_on;
            r_attr  <= n_attr;
            r_wul   <= n_wul;
            r_acc   <= n_acc;
            r_sp    <= n_sp;
            r_pa    <= n_pa;
        end
    end

endmodule

@@ src/atrse_cmdq.sv @@
// Small command queue between front end and serializer.
// Depends on atrse_pkg for the command type.
module atrse_cmdq import atrse_pkg::*; #(
    parameter int DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ src/atrse_back.sv @@
// Back end: expands one command into RTF characters, one beat per cycle
// when o_out is ready, via an output register; uses atrse_pkg, atrse_out_if.
module atrse_back import atrse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    atrse_out_if.source o_out
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CHAR  = 13'b0000000000010,
        ST_PAIR  = 13'b0000000000100,
        ST_LF    = 13'b0000000001000,
        ST_UPRE  = 13'b0000000010000,
        ST_UDIG  = 13'b0000000100000,
        ST_UPOST = 13'b0000001000000,
        ST_ECF   = 13'b0000010000000,
        ST_EFG   = 13'b0000100000000,
        ST_EHL   = 13'b0001000000000,
        ST_EBG   = 13'b0010000000000,
        ST_EUL   = 13'b0100000000000,
        ST_ESP   = 13'b1000000000000
    } t_bstate;

    // strings left-aligned in 80 bits
    localparam logic [79:0] S_LF = {8'h0a, "\\par ", 32'h0};
    localparam logic [79:0] S_U  = {"\\u", 64'h0};
    localparam logic [79:0] S_Q  = {8'h5c, 8'h27, "3f", 48'h0};
    localparam logic [79:0] S_CF = {"\\cf", 56'h0};
    localparam logic [79:0] S_HL = "\\highlight";
    localparam logic [79:0] S_UL = {"\\ul0", 48'h0};

    function automatic logic [7:0] pick(input logic [79:0] s, input logic [3:0] idx);
        logic [79:0] t;
        t = s << {idx, 3'b000};
        return t[79:72];
    endfunction

    // one or two decimal digits of a value 1..16
    function automatic logic [7:0] small_dec(input logic [4:0] x, input logic [3:0] idx);
        logic [4:0] lo;
        lo = x - 5'd10;
        if (x >= 5'd10) begin
            return (idx == 4'd0) ? CH_1[7:0] : CH_0[7:0] + {4'h0, lo[3:0]};
        end
        return CH_0[7:0] + {4'h0, x[3:0]};
    endfunction

    function automatic t_bstate start_of(input t_kind k);
        case (k)
            K_CHAR:  return ST_CHAR;
            K_PAIR:  return ST_PAIR;
            K_LF:    return ST_LF;
            K_UNI:   return ST_UPRE;
            K_ESC:   return ST_ECF;
            default: return ST_CHAR;
        endcase
    endfunction

    t_bstate     r_state;
    logic [3:0]  r_idx;
    t_cmd        r_cmd;
    logic [15:0] r_val;
    logic [2:0]  r_pow;
    logic        r_out_valid;
    logic [15:0] r_out_char;
    logic        r_out_last;

    t_bstate     nxt;
    logic [15:0] n_char;
    logic        seg_done;
    logic        cmd_done;
    logic [3:0]  dig;
    logic        step_en;
    logic        load_en;

    always_comb begin
        dig = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, r_val} >= DEC_MULT[r_pow][k]) begin
                dig = 4'(k);
            end
        end
    end

    always_comb begin
        n_char   = '0;
        seg_done = 1'b0;
        cmd_done = 1'b0;
        nxt      = r_state;
        case (r_state)
            ST_CHAR: begin
                n_char   = r_cmd.value;
                seg_done = 1'b1;
                cmd_done = 1'b1;
            end
            ST_PAIR: begin
                n_char   = (r_idx == 4'd0) ? CH_BSL : r_cmd.value;
                seg_done = (r_idx == 4'd1);
                cmd_done = seg_done;
            end
            ST_LF: begin
                n_char   = {8'h00, pick(S_LF, r_idx)};
                seg_done = (r_idx == 4'd5);
                cmd_done = seg_done;
            end
            ST_UPRE: begin
                n_char   = {8'h00, pick(S_U, r_idx)};
                seg_done = (r_idx == 4'd1);
                nxt      = ST_UDIG;
            end
            ST_UDIG: begin
                n_char   = CH_0 + {12'h000, dig};
                seg_done = (r_pow == 3'd0);
                nxt      = ST_UPOST;
            end
            ST_UPOST: begin
                n_char   = {8'h00, pick(S_Q, r_idx)};
                seg_done = (r_idx == 4'd3);
                cmd_done = seg_done;
            end
            ST_ECF: begin
                n_char   = {8'h00, pick(S_CF, r_idx)};
                seg_done = (r_idx == 4'd2);
                nxt      = ST_EFG;
            end
            ST_EFG: begin
                n_char   = {8'h00, small_dec(r_cmd.fg, r_idx)};
                seg_done = (r_cmd.fg >= 5'd10) ? (r_idx == 4'd1) : 1'b1;
                nxt      = ST_EHL;
            end
            ST_EHL: begin
                n_char   = {8'h00, pick(S_HL, r_idx)};
                seg_done = (r_idx == 4'd9);
                nxt      = ST_EBG;
            end
            ST_EBG: begin
                n_char   = {8'h00, small_dec(r_cmd.bg, r_idx)};
                seg_done = (r_cmd.bg >= 5'd10) ? (r_idx == 4'd1) : 1'b1;
                nxt      = (r_cmd.ul == UL_NONE) ? ST_ESP : ST_EUL;
            end
            ST_EUL: begin
                n_char   = {8'h00, pick(S_UL, r_idx)};
                seg_done = (r_cmd.ul == UL_OFF) ? (r_idx == 4'd3) : (r_idx == 4'd2);
                nxt      = ST_ESP;
            end
            ST_ESP: begin
                n_char   = CH_SP;
                seg_done = 1'b1;
                cmd_done = 1'b1;
            end
            default: begin
                n_char = '0;
            end
        endcase
    end

    assign step_en = (r_state != ST_IDLE) && (!r_out_valid || o_out.ready);
    assign load_en = !i_q_empty && ((r_state == ST_IDLE) || (step_en && cmd_done));
    assign o_pop   = load_en;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (step_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_en) begin
                r_state <= start_of(i_head.kind);
            end else if (step_en) begin
                if (cmd_done) begin
                    r_state <= ST_IDLE;
                end else if (seg_done) begin
                    r_state <= nxt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_char <= n_char;
            r_out_last <= cmd_done;
        end
        if (load_en) begin
            r_idx <= 4'd0;
            r_cmd <= i_head;
            r_val <= i_head.value;
            r_pow <= i_head.upow;
        end else if (step_en) begin
            r_idx <= seg_done ? 4'd0 : r_idx + 4'd1;
            if (r_state == ST_UDIG) begin
                r_val <= r_val - DEC_MULT[r_pow][dig][15:0];
                r_pow <= r_pow - 3'd1;
            end
        end
    end

endmodule

@@ src/ansi_text_to_rtf_stream_encoder_core.sv @@
// ANSI text to RTF stream encoder, top level.
// Input channel i_in: one beat per 16-bit code unit, with mode (0 = text,
// 1 = part of an SGR escape) and seq_end marking an escape's last character.
// Output channel o_out: one beat per RTF character; out_last flags the final
// character produced by an input beat. Beats that produce nothing (CR, escape
// characters other than a closing 'm') are absorbed without output.
// Front end parses SGR codes and classifies each beat into a command; a
// command queue decouples it from the serializer, which emits one character
// per cycle through an output register while the receiver is ready.
// Throughput: the serializer sets the rate, one output character per cycle
// while the receiver is ready; a beat occupies it until its last character
// is out, so plain text sustains one beat per cycle. Input accepts while
// the queue has room.
// Reset: synchronous, active low; clears parse state (attribute 7, no
// underline), empties the queue and drops any pending output.
// Receiver stall: the output register holds its beat; the serializer and
// then the queue back up, and i_in.ready drops once the queue is full.
module ansi_text_to_rtf_stream_encoder_core import atrse_pkg::*; #(
    parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atrse_in_if.sink    i_in,
    atrse_out_if.source o_out
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    // parse and classify
    atrse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // decoupling queue
    atrse_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // character serializer
    atrse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
